[rtl/core/itoaf_pkg.sv]
// shared types, constants and helpers for the integer to ascii formatter
package itoaf_pkg;

    // width of the value used for pointer conversions
    localparam int VALUE_BITS = 64;
    localparam logic [63:0] PTR_MASK =
        (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);

    // widest field and the bcd conversion shape
    localparam logic [5:0] MAX_WIDTH    = 6'd62;
    localparam int         DEC_BITS     = 32;
    localparam int         BCD_DIGITS   = 10;
    localparam int         BITS_PER_STEP = 2;
    localparam int         DABBLE_STEPS = DEC_BITS / BITS_PER_STEP;

    // digit counts before leading zero removal
    localparam logic [4:0] DEC_DIGITS = 5'd10;
    localparam logic [4:0] HEX_DIGITS = 5'd8;
    localparam logic [4:0] PTR_DIGITS = 5'd16;

    // conversion kinds
    typedef enum logic [1:0] {
        KIND_DEC   = 2'd0,
        KIND_LOWER = 2'd1,
        KIND_UPPER = 2'd2,
        KIND_PTR   = 2'd3
    } kind_t;

    // ascii characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;

    // which character the output register takes
    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_X,
        SEL_PAD,
        SEL_MINUS,
        SEL_DIGIT
    } char_sel_t;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      dabble;
        logic      scan_shift;
        logic      calc_pad;
        logic      pad_dec;
        logic      digit_shift;
        logic      emit;
        logic      emit_last;
        char_sel_t sel;
    } itoaf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic conv_last;
        logic lead_zero;
        logic pad_zero;
        logic neg;
        logic is_ptr;
        logic one_left;
        logic out_free;
    } itoaf_stat_t;

    // digit value to ascii
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? CH_UA : CH_LA;
            if (d < 4'd10)
                digit_char = CH_ZERO + {4'b0000, d};
            else
                digit_char = base + {4'b0000, d} - 8'd10;
        end
    endfunction

endpackage

[rtl/core/integer_to_ascii_formatter.sv]
// top level of the integer to ascii formatter
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  input   | in_valid / in_stall  | cmd, value, min_width, zero_pad
//  output  | out_valid / out_stall| char_out, last
//
// - one request is taken at a time; in_stall stays high until
//   its last character has been loaded into the output register
// - signed decimal: bcd conversion (two bits per cycle), then up to 9
//   leading zeros dropped
// - hex: up to 7 leading zeros (pointer: 15) dropped, and for every kind a
//   last scan step closes the scan and sets the pad count
// - then the characters one at a time, plus a step leaving the pad phase;
//   out_stall holds the output register and pauses the sequence
// - reset clears the controller state and the output valid flag
module integer_to_ascii_formatter (
    input  logic        clk,
    input  logic        rst_n,
    // request transaction
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [63:0] value,
    input  logic [5:0]  min_width,
    input  logic        zero_pad,
    // character transaction
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  char_out,
    output logic        last
);

    // command and status between controller and datapath
    itoaf_pkg::itoaf_cmd_t  ctl;
    itoaf_pkg::itoaf_stat_t stat;

    // controller: walks conversion, zero stripping, prefix, pad, sign, digits
    itoaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    // datapath: digit register, bcd unit, pad counter, output register
    itoaf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (value),
        .min_width (min_width),
        .zero_pad  (zero_pad),
        .ctl       (ctl),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .last      (last)
    );

endmodule

[rtl/core/itoaf_dp.sv]
// datapath: digit register, bcd conversion, pad count and output register
module itoaf_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            cmd,
    input  logic [63:0]           value,
    input  logic [5:0]            min_width,
    input  logic                  zero_pad,
    input  itoaf_pkg::itoaf_cmd_t ctl,
    output itoaf_pkg::itoaf_stat_t stat,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            char_out,
    output logic                  last
);

    logic [63:0] dig_reg,   dig_next;
    logic [31:0] mag_reg,   mag_next;
    logic [4:0]  n_reg,     n_next;
    logic [5:0]  width_reg, width_next;
    logic [5:0]  pad_reg,   pad_next;
    logic [3:0]  cnt_reg,   cnt_next;
    logic [7:0]  pad_char_reg, pad_char_next;
    logic        neg_reg,   neg_next;
    logic        dec_reg,   dec_next;
    logic        ptr_reg,   ptr_next;
    logic        upper_reg, upper_next;
    logic        ov_reg,    ov_next;
    logic [7:0]  char_reg,  char_next;
    logic        last_reg,  last_next;

    logic [31:0] low;
    logic        low_neg;
    logic [5:0]  used;
    logic [7:0]  sel_char;
    logic [40:0] step1;
    logic [40:0] step2;

    // one double dabble step: correct each bcd digit, then shift a bit in
    function automatic logic [40:0] dabble1(input logic [39:0] b, input logic bit_in);
        logic [39:0] c;
        begin
            c = b;
            for (int i = 0; i < itoaf_pkg::BCD_DIGITS; i++)
            begin
                if (c[i*4 +: 4] >= 4'd5)
                    c[i*4 +: 4] = c[i*4 +: 4] + 4'd3;
            end
            dabble1 = {c, bit_in};
        end
    endfunction

    assign low     = value[31:0];
    assign low_neg = (cmd == itoaf_pkg::KIND_DEC) && low[31];
    assign used    = {1'b0, n_reg} + {5'b00000, neg_reg};
    assign step1   = dabble1(dig_reg[63:24], mag_reg[31]);
    assign step2   = dabble1(step1[39:0], mag_reg[30]);

    always_comb
    begin
        case (ctl.sel)
            itoaf_pkg::SEL_ZERO:  sel_char = itoaf_pkg::CH_ZERO;
            itoaf_pkg::SEL_X:     sel_char = itoaf_pkg::CH_X;
            itoaf_pkg::SEL_PAD:   sel_char = pad_char_reg;
            itoaf_pkg::SEL_MINUS: sel_char = itoaf_pkg::CH_MINUS;
            itoaf_pkg::SEL_DIGIT: sel_char = itoaf_pkg::digit_char(dig_reg[63:60], upper_reg);
            default:              sel_char = itoaf_pkg::CH_SPACE;
        endcase
    end

    always_comb
    begin
        dig_next      = dig_reg;
        mag_next      = mag_reg;
        n_next        = n_reg;
        width_next    = width_reg;
        pad_next      = pad_reg;
        cnt_next      = cnt_reg;
        pad_char_next = pad_char_reg;
        neg_next      = neg_reg;
        dec_next      = dec_reg;
        ptr_next      = ptr_reg;
        upper_next    = upper_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        ov_next       = ov_reg && out_stall;

        if (ctl.load)
        begin
            neg_next      = low_neg;
            dec_next      = (cmd == itoaf_pkg::KIND_DEC);
            ptr_next      = (cmd == itoaf_pkg::KIND_PTR);
            upper_next    = (cmd == itoaf_pkg::KIND_UPPER);
            mag_next      = low_neg ? (~low + 32'd1) : low;
            width_next    = (min_width > itoaf_pkg::MAX_WIDTH) ? itoaf_pkg::MAX_WIDTH
                                                               : min_width;
            pad_char_next = zero_pad ? itoaf_pkg::CH_ZERO : itoaf_pkg::CH_SPACE;
            cnt_next      = '0;
            case (cmd)
                itoaf_pkg::KIND_DEC:
                begin
                    dig_next = '0;
                    n_next   = itoaf_pkg::DEC_DIGITS;
                end
                itoaf_pkg::KIND_PTR:
                begin
                    dig_next = value & itoaf_pkg::PTR_MASK;
                    n_next   = itoaf_pkg::PTR_DIGITS;
                end
                default:
                begin
                    dig_next = {low, 32'h0};
                    n_next   = itoaf_pkg::HEX_DIGITS;
                end
            endcase
        end

        if (ctl.dabble)
        begin
            dig_next = {step2[39:0], 24'h0};
            mag_next = {mag_reg[29:0], 2'b00};
            cnt_next = cnt_reg + 4'd1;
        end

        if (ctl.scan_shift || ctl.digit_shift)
        begin
            dig_next = {dig_reg[59:0], 4'h0};
            n_next   = n_reg - 5'd1;
        end

        if (ctl.calc_pad)
            pad_next = (width_reg > used) ? (width_reg - used) : 6'd0;

        if (ctl.pad_dec)
            pad_next = pad_reg - 6'd1;

        if (ctl.emit)
        begin
            ov_next   = 1'b1;
            char_next = sel_char;
            last_next = ctl.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg      <= dig_next;
        mag_reg      <= mag_next;
        n_reg        <= n_next;
        width_reg    <= width_next;
        pad_reg      <= pad_next;
        cnt_reg      <= cnt_next;
        pad_char_reg <= pad_char_next;
        neg_reg      <= neg_next;
        dec_reg      <= dec_next;
        ptr_reg      <= ptr_next;
        upper_reg    <= upper_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
    end

    assign stat.conv_last = (cnt_reg == 4'(itoaf_pkg::DABBLE_STEPS - 1));
    assign stat.lead_zero = (dig_reg[63:60] == 4'h0) && (n_reg != 5'd1);
    assign stat.pad_zero  = (pad_reg == 6'd0);
    assign stat.neg       = neg_reg;
    assign stat.is_ptr    = ptr_reg;
    assign stat.one_left  = (n_reg == 5'd1);
    assign stat.out_free  = !ov_reg || !out_stall;

    assign out_valid = ov_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (!ov_reg || !out_stall))
        else $error("character written over a stalled transaction");

    a_keep_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.scan_shift || ctl.digit_shift) |-> (n_reg != 5'd0))
        else $error("digit count underflow");

    a_pad_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pad_dec |-> (pad_reg != 6'd0))
        else $error("pad count underflow");

    a_dabble_dec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.dabble |-> dec_reg)
        else $error("bcd conversion on a hex request");
`endif

endmodule

[rtl/core/itoaf_ctrl.sv]
// controller: sequences conversion, leading zero removal and character output
module itoaf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [1:0]             cmd,
    output logic                   in_stall,
    input  itoaf_pkg::itoaf_stat_t stat,
    output itoaf_pkg::itoaf_cmd_t  ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_PFX0,
        ST_PFXX,
        ST_PAD,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.sel    = itoaf_pkg::SEL_DIGIT;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = (cmd == itoaf_pkg::KIND_DEC) ? ST_CONV : ST_SCAN;
                end
            end
            ST_CONV:
            begin
                ctl.dabble = 1'b1;
                if (stat.conv_last)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (stat.lead_zero)
                    ctl.scan_shift = 1'b1;
                else
                begin
                    ctl.calc_pad = 1'b1;
                    state_next   = stat.is_ptr ? ST_PFX0 : ST_PAD;
                end
            end
            ST_PFX0:
            begin
                if (stat.out_free)
                begin
                    ctl.emit   = 1'b1;
                    ctl.sel    = itoaf_pkg::SEL_ZERO;
                    state_next = ST_PFXX;
                end
            end
            ST_PFXX:
            begin
                if (stat.out_free)
                begin
                    ctl.emit   = 1'b1;
                    ctl.sel    = itoaf_pkg::SEL_X;
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (stat.pad_zero)
                    state_next = stat.neg ? ST_SIGN : ST_DIGITS;
                else if (stat.out_free)
                begin
                    ctl.emit    = 1'b1;
                    ctl.sel     = itoaf_pkg::SEL_PAD;
                    ctl.pad_dec = 1'b1;
                end
            end
            ST_SIGN:
            begin
                if (stat.out_free)
                begin
                    ctl.emit   = 1'b1;
                    ctl.sel    = itoaf_pkg::SEL_MINUS;
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (stat.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.sel         = itoaf_pkg::SEL_DIGIT;
                    ctl.emit_last   = stat.one_left;
                    ctl.digit_shift = !stat.one_left;
                    if (stat.one_left)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[test/integer_to_ascii_formatter_checker.sv]
// request and character monitor with the formatting predictor and the text comparison
`timescale 1ns / 100ps

module integer_to_ascii_formatter_checker
    import itoaf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [63:0] value,
    input  logic [5:0]  min_width,
    input  logic        zero_pad,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  char_out,
    input  logic        last,
    output int          error_count,
    output int          outstanding
);

    localparam int         FIELD_LIMIT = 62;
    localparam logic [7:0] ASC_ZERO    = "0";
    localparam logic [7:0] ASC_X       = "x";
    localparam logic [7:0] ASC_MINUS   = "-";
    localparam logic [7:0] ASC_SPACE   = " ";
    localparam logic [7:0] ASC_UPPER_A = "A";
    localparam logic [7:0] ASC_LOWER_A = "a";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    text_char_t expected_text[$];

    // builds the character stream of one request and queues it
    function automatic void format_request(kind_t kind, logic [63:0] val,
                                           logic [5:0] width_in, logic zero_fill);
        logic [63:0] mag;
        logic [63:0] radix;
        logic        negative;
        logic [7:0]  digit_buf[64];
        logic [7:0]  letter_base;
        logic [7:0]  fill;
        logic [7:0]  text[$];
        logic [3:0]  d;
        text_char_t  tc;
        int          ndig;
        int          field;
        int          used;
        radix       = 64'd16;
        negative    = 1'b0;
        ndig        = 0;
        field       = (int'(width_in) > FIELD_LIMIT) ? FIELD_LIMIT : int'(width_in);
        fill        = zero_fill ? ASC_ZERO : ASC_SPACE;
        letter_base = (kind == KIND_UPPER) ? ASC_UPPER_A : ASC_LOWER_A;
        case (kind)
            KIND_DEC:
            begin
                radix = 64'd10;
                if (val[31])
                begin
                    negative = 1'b1;
                    mag = 64'h1_0000_0000 - {32'h0, val[31:0]};
                end
                else
                    mag = {32'h0, val[31:0]};
            end
            KIND_PTR:
            begin
                mag = val & PTR_MASK;
                text.push_back(ASC_ZERO);
                text.push_back(ASC_X);
            end
            default:
                mag = {32'h0, val[31:0]};
        endcase
        do
        begin
            d = 4'(mag % radix);
            mag = mag / radix;
            digit_buf[ndig] = (d < 4'd10) ? ASC_ZERO + {4'h0, d}
                                          : letter_base + {4'h0, d} - 8'd10;
            ndig++;
        end
        while (mag != 0);
        // pad goes ahead of the sign
        for (used = ndig + int'(negative); used < field; used++)
            text.push_back(fill);
        if (negative)
            text.push_back(ASC_MINUS);
        for (int i = ndig - 1; i >= 0; i--)
            text.push_back(digit_buf[i]);
        foreach (text[i])
        begin
            tc.ch   = text[i];
            tc.last = (i == text.size() - 1);
            expected_text.push_back(tc);
        end
    endfunction

    function automatic void note_mismatch(text_char_t want, text_char_t got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     want.ch, want.last, got.ch, got.last);
    endfunction

    always @(posedge clk)
    begin : watch
        text_char_t got;
        text_char_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                format_request(kind_t'(cmd), value, min_width, zero_pad);
            if (out_valid && !out_stall)
            begin
                got.ch   = char_out;
                got.last = last;
                if (expected_text.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected char %h last %b with nothing pending",
                                 got.ch, got.last);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (got.ch !== want.ch || got.last !== want.last)
                        note_mismatch(want, got);
                end
            end
            outstanding = expected_text.size();
        end
    end

endmodule

[test/integer_to_ascii_formatter_tb.sv]
// stimulus, output back-pressure and verdict for the integer to ascii formatter
`timescale 1ns / 100ps

module integer_to_ascii_formatter_tb;
    import itoaf_pkg::*;

    localparam int RANDOM_ITEMS = 160;
    // settling time after the last character, covers the longest decimal conversion
    localparam int TAIL_CYCLES  = 60;
    // worst case is roughly 200 requests of 64 characters each, every one stalled by the longest idle_gap
    localparam int TIMEOUT_NS   = 25_000_000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [63:0] value;
    logic [5:0]  min_width;
    logic        zero_pad;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  char_out;
    logic        last;
    int          error_count;
    int          outstanding;

    integer_to_ascii_formatter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .value     (value),
        .min_width (min_width),
        .zero_pad  (zero_pad),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .last      (last)
    );

    // monitor sits beside the block and only listens to both channels
    integer_to_ascii_formatter_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .value       (value),
        .min_width   (min_width),
        .zero_pad    (zero_pad),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_out    (char_out),
        .last        (last),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle length: mostly none, often a few cycles, now and then a long one
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(4, 1);
        else
            return $urandom_range(40, 10);
    endfunction

    // one request transaction; valid drops only when there is a gap to insert,
    // so back-to-back transactions keep valid high without a glitch
    task automatic send_request(kind_t kind, logic [63:0] val, logic [5:0] width,
                                logic zero_fill);
        int gap;
        gap = idle_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= kind;
        value     <= val;
        min_width <= width;
        zero_pad  <= zero_fill;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // hold the sender back until every queued character has come out
    task automatic drain_output();
        in_valid <= 1'b0;
        @(negedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    // receiver back-pressure: alternating free and stalled stretches, the free
    // ones sometimes long enough to give runs with no stalling at all
    initial
    begin : stall_gen
        int free_len;
        int stall_len;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            free_len = ($urandom_range(9) == 0) ? $urandom_range(80, 30)
                                                : $urandom_range(8, 1);
            repeat (free_len) @(posedge clk);
            stall_len = idle_gap();
            if (stall_len != 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // guard against a hang: anything still pending this late is a failure
    initial
    begin
        #(TIMEOUT_NS);
        $display("integer_to_ascii_formatter verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [63:0] val;
        logic [5:0]  width;
        kind_t       kind;
        int          pick;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = KIND_DEC;
        value     = 64'h0;
        min_width = 6'd0;
        zero_pad  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero in every kind, extremes of the value and the width
        send_request(KIND_DEC,   64'h0,                   6'd0,  1'b0);
        send_request(KIND_DEC,   64'h0,                   6'd5,  1'b1);
        send_request(KIND_DEC,   64'h0000_0000_7fff_ffff, 6'd0,  1'b0);
        // most negative decimal, magnitude must not wrap
        send_request(KIND_DEC,   64'h0000_0000_8000_0000, 6'd0,  1'b0);
        // zero padding lands ahead of the minus sign
        send_request(KIND_DEC,   64'hffff_ffff_ffff_fffb, 6'd5,  1'b1);
        send_request(KIND_DEC,   64'h0000_0000_ffff_fffb, 6'd5,  1'b0);
        // width of 63 is clamped to 62
        send_request(KIND_DEC,   64'h0000_0000_ffff_ffff, 6'd63, 1'b1);
        // upper half ignored for decimal and plain hex
        send_request(KIND_DEC,   64'hffff_ffff_0000_007b, 6'd1,  1'b0);
        send_request(KIND_DEC,   64'h0000_0000_0000_0001, 6'd1,  1'b1);
        send_request(KIND_LOWER, 64'h0,                   6'd0,  1'b0);
        send_request(KIND_LOWER, 64'h1234_5678_ffff_ffff, 6'd0,  1'b0);
        send_request(KIND_LOWER, 64'h0000_0000_0000_0010, 6'd2,  1'b1);
        send_request(KIND_LOWER, 64'h0000_0000_abcd_ef01, 6'd62, 1'b0);
        send_request(KIND_UPPER, 64'h0,                   6'd3,  1'b1);
        send_request(KIND_UPPER, 64'haaaa_5555_dead_beef, 6'd12, 1'b1);
        send_request(KIND_UPPER, 64'h0000_0000_00ab_cdef, 6'd10, 1'b0);
        send_request(KIND_UPPER, 64'h0000_0000_ffff_ffff, 6'd63, 1'b0);
        // pointer keeps the full value and the prefix sits outside the width
        send_request(KIND_PTR,   64'h0,                   6'd0,  1'b0);
        send_request(KIND_PTR,   64'hffff_ffff_ffff_ffff, 6'd0,  1'b1);
        send_request(KIND_PTR,   64'h0000_0000_1234_5678, 6'd20, 1'b1);
        send_request(KIND_PTR,   64'h8000_0000_0000_0000, 6'd63, 1'b0);
        send_request(KIND_PTR,   64'h0000_0000_0000_00fe, 6'd4,  1'b0);
        drain_output();

        // random: small and boundary values, every magnitude, mostly narrow fields
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = kind_t'($urandom_range(3));
            val  = {$urandom, $urandom};
            case ($urandom_range(5))
                0: val[31:0] = $urandom_range(20);
                1: val[31:0] = 32'h0 - 32'($urandom_range(20, 1));
                2: val = val >> $urandom_range(63);
                3:
                begin
                    case ($urandom_range(3))
                        0: val[31:0] = 32'h7fff_ffff;
                        1: val[31:0] = 32'h8000_0000;
                        2: val[31:0] = 32'hffff_ffff;
                        default: val[31:0] = 32'h8000_0001;
                    endcase
                end
                default: ;
            endcase
            pick = $urandom_range(99);
            if (pick < 70)
                width = 6'($urandom_range(12));
            else if (pick < 92)
                width = 6'($urandom_range(30, 13));
            else
                width = 6'($urandom_range(63, 31));
            send_request(kind, val, width, 1'($urandom_range(1)));
            if (i % 60 == 59)
                drain_output();
        end
        in_valid <= 1'b0;

        // let every queued character through, then watch for strays
        @(negedge clk);
        wait (outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("integer_to_ascii_formatter verification clean");
        else
            $display("integer_to_ascii_formatter verification failed");
        $finish;
    end

endmodule
